// ===== sv/pte_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and character classification functions for the
// PDF token byte escaper. No dependencies.
package pte_pkg;

    // Token kinds carried in tuser
    localparam logic [1:0] KIND_NAME = 2'd0;
    localparam logic [1:0] KIND_LIT  = 2'd1;
    localparam logic [1:0] KIND_HEX  = 2'd2;

    localparam int unsigned RUN_MAX     = 4;
    localparam int unsigned RUN_IDX_W   = $clog2(RUN_MAX);
    localparam int unsigned RUN_CNT_W   = $clog2(RUN_MAX + 1);
    localparam int unsigned QDEPTH      = 2;
    localparam int unsigned QPTR_W      = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int unsigned QCNT_W      = $clog2(QDEPTH + 1);

    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [3:0] NIB_MASK  = 4'hF;

    // One serialized run: up to four characters and the index of the last one
    typedef struct packed {
        logic [RUN_MAX-1:0][7:0] chars;
        logic [RUN_IDX_W-1:0]    last_idx;
    } run_t;

    // Queue status seen by the front and back parts
    typedef struct packed {
        logic full;
        logic valid;
    } q_status_t;

    function automatic logic [7:0] hex_digit(input logic [3:0] nib);
        logic [7:0] d;
        if (nib < 4'd10)
            d = 8'h30 + {4'h0, nib};
        else
            d = 8'h37 + {4'h0, nib};
        return d;
    endfunction

    function automatic logic name_needs_escape(input logic [7:0] c);
        logic esc;
        if (c < 8'h21 || c > 8'h7E)
            esc = 1'b1;
        else
        begin
            case (c)
                8'h23, 8'h25, 8'h28, 8'h29, 8'h2F,
                8'h3C, 8'h3E, 8'h5B, 8'h5D, 8'h7B, 8'h7D: esc = 1'b1;
                default: esc = 1'b0;
            endcase
        end
        return esc;
    endfunction

    // Escape letter for a literal string byte, zero when copied bare
    function automatic logic [7:0] lit_escape(input logic [7:0] c);
        logic [7:0] e;
        case (c)
            8'h0A:   e = 8'h6E;
            8'h0D:   e = 8'h72;
            8'h09:   e = 8'h74;
            8'h08:   e = 8'h62;
            8'h0C:   e = 8'h66;
            8'h28:   e = 8'h28;
            8'h29:   e = 8'h29;
            8'h5C:   e = 8'h5C;
            default: e = 8'h00;
        endcase
        return e;
    endfunction

endpackage

// ===== sv/pte_classify.sv =====
`timescale 1ns / 1ps
// Front part: classifies one input byte and builds its run of output
// characters for the queue. Depends on pte_pkg.
module pte_classify
    import pte_pkg::*;
(
    input  logic [1:0]           opcode,
    input  logic [7:0]           data_byte,
    input  logic                 first_flag,
    input  logic                 last_flag,
    input  logic                 no_byte,
    output run_t                 run,
    output logic [RUN_CNT_W-1:0] run_len
);

    logic [RUN_MAX-1:0][7:0] buf_c;
    logic [RUN_CNT_W-1:0]    n;
    logic [7:0]              esc;
    logic [7:0]              hi_dig;
    logic [7:0]              lo_dig;

    assign hi_dig = hex_digit(data_byte[7:4]);
    assign lo_dig = hex_digit(data_byte[3:0] & NIB_MASK);
    assign esc    = lit_escape(data_byte);

    always_comb
    begin
        buf_c = '0;
        n     = '0;
        if (opcode == KIND_NAME || opcode == KIND_LIT || opcode == KIND_HEX)
        begin
            if (first_flag)
            begin
                case (opcode)
                    KIND_NAME: buf_c[n[RUN_IDX_W-1:0]] = CH_SLASH;
                    KIND_LIT:  buf_c[n[RUN_IDX_W-1:0]] = CH_LPAREN;
                    default:   buf_c[n[RUN_IDX_W-1:0]] = CH_LT;
                endcase
                n = n + 1'b1;
            end
            if (!no_byte)
            begin
                case (opcode)
                    KIND_NAME:
                    begin
                        if (name_needs_escape(data_byte))
                        begin
                            buf_c[n[RUN_IDX_W-1:0]] = CH_HASH;
                            n = n + 1'b1;
                            buf_c[n[RUN_IDX_W-1:0]] = hi_dig;
                            n = n + 1'b1;
                            buf_c[n[RUN_IDX_W-1:0]] = lo_dig;
                            n = n + 1'b1;
                        end
                        else
                        begin
                            buf_c[n[RUN_IDX_W-1:0]] = data_byte;
                            n = n + 1'b1;
                        end
                    end
                    KIND_LIT:
                    begin
                        if (esc != 8'h00)
                        begin
                            buf_c[n[RUN_IDX_W-1:0]] = CH_BSLASH;
                            n = n + 1'b1;
                            buf_c[n[RUN_IDX_W-1:0]] = esc;
                            n = n + 1'b1;
                        end
                        else
                        begin
                            buf_c[n[RUN_IDX_W-1:0]] = data_byte;
                            n = n + 1'b1;
                        end
                    end
                    default:
                    begin
                        buf_c[n[RUN_IDX_W-1:0]] = hi_dig;
                        n = n + 1'b1;
                        buf_c[n[RUN_IDX_W-1:0]] = lo_dig;
                        n = n + 1'b1;
                    end
                endcase
            end
            // names have no closing delimiter
            if (last_flag && opcode != KIND_NAME)
            begin
                buf_c[n[RUN_IDX_W-1:0]] = (opcode == KIND_LIT) ? CH_RPAREN : CH_GT;
                n = n + 1'b1;
            end
        end
    end

    assign run.chars    = buf_c;
    assign run.last_idx = (n == '0) ? '0 : RUN_IDX_W'(n - 1'b1);
    assign run_len      = n;

endmodule

// ===== sv/pte_queue.sv =====
`timescale 1ns / 1ps
// Short run queue between the classifier and the serializer.
// Depends on pte_pkg.
module pte_queue
    import pte_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  run_t      push_run,
    input  logic      pop,
    output run_t      head_run,
    output q_status_t status
);

    run_t              entry_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        logic [QPTR_W-1:0] r;
        if (p == QPTR_W'(QDEPTH - 1))
            r = '0;
        else
            r = p + 1'b1;
        return r;
    endfunction

    assign status.full  = (count_reg == QCNT_W'(QDEPTH));
    assign status.valid = (count_reg != '0);
    assign head_run     = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_run;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== sv/pte_serialize.sv =====
`timescale 1ns / 1ps
// Back part: walks the run at the queue head one character per cycle, while
// the output is not stalled, into a registered output stage. Depends on pte_pkg.
module pte_serialize
    import pte_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  q_status_t  q_status,
    input  run_t       head_run,
    output logic       pop,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,
    output logic       m_axis_tlast
);

    run_t                 run_reg;
    logic [RUN_IDX_W-1:0] idx_reg;
    logic [RUN_IDX_W-1:0] idx_next;
    logic                 busy_reg;
    logic                 busy_next;
    logic                 out_valid_reg;
    logic [7:0]           out_char_reg;
    logic                 out_last_reg;
    logic                 out_load;
    logic                 emit;
    logic                 done;

    assign out_load = !out_valid_reg || m_axis_tready;
    assign emit     = busy_reg && out_load;
    assign done     = emit && (idx_reg == run_reg.last_idx);
    // take the next run in the same cycle the current one finishes
    assign pop      = q_status.valid && (!busy_reg || done);

    always_comb
    begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (pop)
        begin
            busy_next = 1'b1;
            idx_next  = '0;
        end
        else if (done)
            busy_next = 1'b0;
        else if (emit)
            idx_next = idx_reg + 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            run_reg <= head_run;
        if (emit)
        begin
            out_char_reg <= run_reg.chars[idx_reg];
            out_last_reg <= (idx_reg == run_reg.last_idx);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
            if (out_load)
                out_valid_reg <= emit;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_char_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

// ===== sv/pdf_token_byte_escaper.sv =====
`timescale 1ns / 1ps
// Top level of the PDF token byte escaper: classifier, run queue, serializer.
// Depends on pte_pkg, pte_classify, pte_queue, pte_serialize.
//
// Each accepted byte becomes a run of one to four ASCII characters (opening
// delimiter, the byte bare or escaped, closing delimiter), sent one character
// per cycle while the receiver is ready, with tlast on the last character of
// the run; items that produce nothing (unused kind, empty item without flags)
// are accepted and dropped. Output goes through a single-character output
// register; the input side takes one transaction per cycle while the two-run
// queue has room. A character passes through the queue entry, the run
// register and the output register. No configuration, no state across items.
module pdf_token_byte_escaper
    import pte_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
    input  logic [3:0] s_axis_tuser,   // [1:0] opcode, [2] first_flag, [3] no_byte
    input  logic       s_axis_tlast,   // last_flag
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_char
    output logic       m_axis_tlast    // end_of_run
);

    run_t                 cls_run;
    logic [RUN_CNT_W-1:0] cls_len;
    run_t                 head_run;
    q_status_t            q_status;
    logic                 push;
    logic                 pop;

    pte_classify u_classify (
        .opcode     (s_axis_tuser[1:0]),
        .data_byte  (s_axis_tdata),
        .first_flag (s_axis_tuser[2]),
        .last_flag  (s_axis_tlast),
        .no_byte    (s_axis_tuser[3]),
        .run        (cls_run),
        .run_len    (cls_len)
    );

    assign s_axis_tready = !q_status.full;
    // drop transactions that produce no characters
    assign push = s_axis_tvalid && s_axis_tready && (cls_len != '0);

    pte_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_run (cls_run),
        .pop      (pop),
        .head_run (head_run),
        .status   (q_status)
    );

    pte_serialize u_serialize (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_status      (q_status),
        .head_run      (head_run),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

// ===== sv/pte_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the PDF token byte escaper, bound to the top level.
// Depends on pdf_token_byte_escaper.
module pte_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tlast
);

    // a stalled output transaction holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output changed while stalled");

    // nothing leaves the block once reset has been seen at a clock edge
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |=> !m_axis_tvalid)
        else $error("output valid during reset");

    // input backpressure only while the serializer has a character out
    a_full_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with output idle");

endmodule

bind pdf_token_byte_escaper pte_checker u_pte_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

// ===== sim/pdf_token_byte_escaper_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for pdf_token_byte_escaper: bursty stream stimulus,
// a stalling receiver and a character-level predictor of the escaping rules.
// Depends on pte_pkg and the escaper RTL.
module pdf_token_byte_escaper_test;
    import pte_pkg::*;

    // Opcode 3 carries no meaning and must be dropped by the block
    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int unsigned RANDOM_ITEMS = 180;
    localparam int unsigned MAX_REPORTS = 10;
    localparam int unsigned DRAIN_CYCLES = 16;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data_byte;
        logic       first_flag;
        logic       last_flag;
        logic       no_byte;
    } token_item_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       end_of_run;
    } token_char_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = 8'h00;   // [7:0] data_byte
    logic [3:0] s_axis_tuser = 4'h0;    // [1:0] opcode, [2] first_flag, [3] no_byte
    logic       s_axis_tlast = 1'b0;    // last_flag
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;           // [7:0] out_char
    logic       m_axis_tlast;           // end_of_run

    token_item_t pending_bytes[$];
    token_char_t expected_chars[$];
    token_item_t cur_item;
    token_item_t next_item;
    token_char_t want_char;

    int unsigned error_count = 0;
    int unsigned accepted_count = 0;
    int unsigned checked_count = 0;
    int unsigned token_count = 0;
    int          burst_left = 0;
    int          gap_left = 0;
    int unsigned stall_tick = 0;
    int unsigned stall_mode = 0;

    logic [7:0] special_bytes [24] = '{
        8'h00, 8'h08, 8'h09, 8'h0A, 8'h0C, 8'h0D, 8'h20, 8'h21,
        8'h23, 8'h25, 8'h28, 8'h29, 8'h2F, 8'h3C, 8'h3E, 8'h5B,
        8'h5C, 8'h5D, 8'h7B, 8'h7D, 8'h7E, 8'h7F, 8'h80, 8'hFF
    };

    pdf_token_byte_escaper i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 clk = ~clk;

    function automatic logic [7:0] nibble_char(input logic [3:0] nib);
        return (nib > 4'd9) ? (8'h41 + {4'h0, nib} - 8'd10) : (8'h30 + {4'h0, nib});
    endfunction

    function automatic logic is_name_regular(input logic [7:0] c);
        logic ok;
        ok = (c >= 8'h21) && (c <= 8'h7E);
        case (c)
            "#", "%", "(", ")", "/", "<", ">", "[", "]", "{", "}": ok = 1'b0;
            default: ;
        endcase
        return ok;
    endfunction

    // Work out the characters one accepted item must produce
    task automatic serialize_item(input token_item_t it);
        logic [7:0] run [$];
        logic [7:0] esc;
        if (it.kind == KIND_UNUSED)
            return;
        if (it.first_flag)
        begin
            case (it.kind)
                KIND_NAME: run.push_back(CH_SLASH);
                KIND_LIT:  run.push_back(CH_LPAREN);
                default:   run.push_back(CH_LT);
            endcase
        end
        if (!it.no_byte)
        begin
            case (it.kind)
                KIND_NAME:
                begin
                    if (is_name_regular(it.data_byte))
                        run.push_back(it.data_byte);
                    else
                    begin
                        run.push_back(CH_HASH);
                        run.push_back(nibble_char(it.data_byte[7:4]));
                        run.push_back(nibble_char(it.data_byte[3:0]));
                    end
                end
                KIND_LIT:
                begin
                    case (it.data_byte)
                        8'h0A:             esc = "n";
                        8'h0D:             esc = "r";
                        8'h09:             esc = "t";
                        8'h08:             esc = "b";
                        8'h0C:             esc = "f";
                        "(", ")", "\\":    esc = it.data_byte;
                        default:           esc = 8'h00;
                    endcase
                    if (esc != 8'h00)
                        run.push_back(CH_BSLASH);
                    run.push_back((esc != 8'h00) ? esc : it.data_byte);
                end
                default:
                begin
                    run.push_back(nibble_char(it.data_byte[7:4]));
                    run.push_back(nibble_char(it.data_byte[3:0]));
                end
            endcase
        end
        if (it.last_flag && it.kind != KIND_NAME)
            run.push_back((it.kind == KIND_LIT) ? CH_RPAREN : CH_GT);
        foreach (run[k])
            expected_chars.push_back('{out_char: run[k], end_of_run: (k == run.size() - 1)});
    endtask

    task automatic note_failure(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task automatic queue_item(input logic [1:0] kind, input logic [7:0] data_byte,
                              input logic first_flag, input logic last_flag,
                              input logic no_byte);
        pending_bytes.push_back('{kind, data_byte, first_flag, last_flag, no_byte});
    endtask

    // Driver: bursts of random length separated by random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                serialize_item(cur_item);
                accepted_count++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (pending_bytes.size() > 0)
                begin
                    next_item = pending_bytes.pop_front();
                    cur_item = next_item;
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= next_item.data_byte;
                    s_axis_tuser  <= {next_item.no_byte, next_item.first_flag, next_item.kind};
                    s_axis_tlast  <= next_item.last_flag;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = $urandom_range(1, 16);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: check each output transaction, stall on a changing pattern
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_chars.size() == 0)
                    note_failure($sformatf("unexpected char %h tlast %b",
                                           m_axis_tdata, m_axis_tlast));
                else
                begin
                    want_char = expected_chars.pop_front();
                    checked_count++;
                    if (m_axis_tdata !== want_char.out_char)
                        note_failure($sformatf("out_char expected %h actual %h",
                                               want_char.out_char, m_axis_tdata));
                    if (m_axis_tlast !== want_char.end_of_run)
                        note_failure($sformatf("end_of_run expected %b actual %b (char %h)",
                                               want_char.end_of_run, m_axis_tlast,
                                               want_char.out_char));
                end
            end
            stall_tick++;
            if (stall_tick >= 60)
            begin
                stall_tick = 0;
                stall_mode = $urandom_range(0, 3);
            end
            case (stall_mode)
                0:       m_axis_tready <= 1'b1;
                1:       m_axis_tready <= 1'($urandom_range(0, 1));
                2:       m_axis_tready <= (stall_tick % 5) < 3;
                default: m_axis_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    initial
    begin
        int unsigned counted;
        int unsigned tok_len;
        logic [1:0]  kind;
        logic [7:0]  data_byte;
        logic        empty_tok;

        // Directed: delimiters, escape boundaries, empty tokens, unused opcode
        queue_item(KIND_NAME, "A",   1'b1, 1'b0, 1'b0);
        queue_item(KIND_NAME, 8'h00, 1'b0, 1'b0, 1'b0);
        queue_item(KIND_NAME, 8'h20, 1'b0, 1'b0, 1'b0);
        queue_item(KIND_NAME, 8'h21, 1'b0, 1'b0, 1'b0);
        queue_item(KIND_NAME, 8'h7E, 1'b0, 1'b0, 1'b0);
        queue_item(KIND_NAME, 8'h7F, 1'b0, 1'b0, 1'b0);
        queue_item(KIND_NAME, "#",   1'b0, 1'b0, 1'b0);
        queue_item(KIND_NAME, "\\",  1'b0, 1'b1, 1'b0);
        queue_item(KIND_NAME, 8'hFF, 1'b1, 1'b1, 1'b0);
        queue_item(KIND_LIT,  8'h0A, 1'b1, 1'b0, 1'b0);
        queue_item(KIND_LIT,  8'h0D, 1'b0, 1'b0, 1'b0);
        queue_item(KIND_LIT,  8'h09, 1'b0, 1'b0, 1'b0);
        queue_item(KIND_LIT,  8'h08, 1'b0, 1'b0, 1'b0);
        queue_item(KIND_LIT,  8'h0C, 1'b0, 1'b0, 1'b0);
        queue_item(KIND_LIT,  "(",   1'b0, 1'b0, 1'b0);
        queue_item(KIND_LIT,  ")",   1'b0, 1'b0, 1'b0);
        queue_item(KIND_LIT,  "\\",  1'b0, 1'b0, 1'b0);
        queue_item(KIND_LIT,  8'hFF, 1'b0, 1'b1, 1'b0);
        queue_item(KIND_HEX,  8'h00, 1'b1, 1'b0, 1'b0);
        queue_item(KIND_HEX,  8'hA5, 1'b0, 1'b1, 1'b0);
        queue_item(KIND_HEX,  8'hFF, 1'b1, 1'b1, 1'b0);
        queue_item(KIND_NAME, 8'h55, 1'b1, 1'b1, 1'b1);
        queue_item(KIND_LIT,  8'hAA, 1'b1, 1'b1, 1'b1);
        queue_item(KIND_HEX,  8'h00, 1'b1, 1'b1, 1'b1);
        queue_item(KIND_HEX,  8'h3C, 1'b0, 1'b0, 1'b1);
        queue_item(KIND_UNUSED, 8'h28, 1'b1, 1'b1, 1'b0);
        token_count = 12;

        // Random: mostly well-formed tokens, some loose noise items
        counted = 0;
        while (counted < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                kind = 2'($urandom_range(0, 3));
                queue_item(kind, 8'($urandom), 1'($urandom_range(0, 1)),
                           1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                if (kind != KIND_UNUSED)
                    counted++;
            end
            else
            begin
                kind = 2'($urandom_range(0, 2));
                empty_tok = ($urandom_range(0, 9) == 0);
                tok_len = empty_tok ? 1 : $urandom_range(1, 6);
                for (int unsigned i = 0; i < tok_len; i++)
                begin
                    data_byte = ($urandom_range(0, 2) == 0) ?
                                special_bytes[5'($urandom_range(0, 23))] : 8'($urandom);
                    queue_item(kind, data_byte, i == 0, i == tok_len - 1, empty_tok);
                end
                counted += tok_len;
                token_count++;
            end
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_bytes.size() > 0 || s_axis_tvalid)
            @(posedge clk);
        while (expected_chars.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (expected_chars.size() > 0)
            note_failure($sformatf("%0d chars never arrived", expected_chars.size()));
        $display("Escaped %0d input bytes across about %0d tokens of all three kinds,",
                 accepted_count, token_count);
        $display("compared %0d output characters, %0d errors.", checked_count, error_count);
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/pte_pkg.sv
sv/pte_classify.sv
sv/pte_queue.sv
sv/pte_serialize.sv
sv/pdf_token_byte_escaper.sv
sv/pte_checker.sv
sim/pdf_token_byte_escaper_test.sv
